>>> sv/page_buffer_pool_replacement_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the page buffer pool replacement core
// ---------------------------------------------------------------------------
`ifndef PAGE_BUFFER_POOL_REPLACEMENT_CORE_ASSERT_SVH
`define PAGE_BUFFER_POOL_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define PBPR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page buffer pool assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define PBPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page buffer pool assertion failed");

`endif

>>> sv/pbpr_pkg.sv
// ---------------------------------------------------------------------------
// pbpr_pkg
// Shared types, widths and codes of the page buffer pool replacement core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pbpr_pkg;

   localparam int DEF_NUM_FRAMES = 8;
   localparam int PAGE_W   = 20;
   localparam int PIN_W    = 8;
   localparam int HIST_W   = 4;
   localparam int CNT_W    = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int FRAME_W  = 3;
   localparam int REQ_W    = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [PIN_W-1:0]  PIN_MAX  = '1;
   localparam logic [HIST_W-1:0] HIST_MAX = '1;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PIN   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_UNPIN = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DIRTY = 3'd2;
   localparam logic [REQ_W-1:0] REQ_FORCE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FLUSH = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_PIN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ALL_PIN   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PIN_FULL  = 3'd4;

   // policy codes
   localparam logic [MODE_W-1:0] POL_FIFO = 2'd0;
   localparam logic [MODE_W-1:0] POL_LRU  = 2'd1;
   localparam logic [MODE_W-1:0] POL_LRUK = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIST_K = 1'b1;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [PAGE_W-1:0] page_number;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame_index;
      logic                load_from_disk;
      logic                write_back;
      logic [PAGE_W-1:0]   write_back_page;
      logic [CNT_W-1:0]    read_count;
      logic [CNT_W-1:0]    write_count;
      logic                last;
   } rsp_payload_type;

   typedef struct packed {
      logic load_req;
      logic scan_en;
      logic apply;
      logic flush_emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_flush;
      logic any_dirty;
      logic flush_hit;
      logic flush_more;
   } dp_stat_type;

endpackage
`default_nettype wire

>>> sv/pbpr_ctrl.sv
// ---------------------------------------------------------------------------
// pbpr_ctrl
// Sequencer: accepts a request, walks the frame table one frame per cycle,
// then applies the update or walks the dirty frames of a flush.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pbpr_ctrl
   import pbpr_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire dp_stat_type                   stat,
   output dp_cmd_type                         cmd,
   output logic [$clog2(NUM_FRAMES)-1:0]      idx
);
   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_FRAMES - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   assign idx       = idx_ff;
   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               idx_in       = '0;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.is_flush) begin
               state_in = stat.any_dirty ? S_FLUSH : S_APPLY;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (idx_ff == IDX_LAST) begin
               idx_in   = '0;
               state_in = S_APPLY;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_APPLY: begin
            if (stat.out_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (stat.flush_hit) begin
               if (stat.out_free) begin
                  cmd.flush_emit = 1'b1;
                  if (stat.flush_more) begin
                     idx_in = idx_ff + 1'b1;
                  end else begin
                     idx_in   = '0;
                     state_in = S_IDLE;
                  end
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/pbpr_dpath.sv
// ---------------------------------------------------------------------------
// pbpr_dpath
// Frame table, scan accumulators, update logic, IO counters and the
// result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pbpr_dpath
   import pbpr_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire req_payload_type               req_data,
   input  wire logic                          csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_write_data,
   input  wire dp_cmd_type                    cmd,
   input  wire logic [$clog2(NUM_FRAMES)-1:0] idx,
   output dp_stat_type                        stat,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rsp_payload_type                    rsp_data
);
   localparam int IDX_W  = $clog2(NUM_FRAMES);
   localparam int UCNT_W = $clog2(NUM_FRAMES + 1);

   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  fidx;
      logic [IDX_W-1:0]  rank;
      logic [HIST_W-1:0] hist;
      logic [PIN_W-1:0]  pin;
      logic              dirty;
   } cand_type;

   // configuration
   logic [MODE_W-1:0] mode_ff;
   logic [HIST_W-1:0] hist_k_ff;

   // frame table
   logic [PAGE_W-1:0] page_ff  [NUM_FRAMES];
   logic [PAGE_W-1:0] page_in  [NUM_FRAMES];
   logic [IDX_W-1:0]  rank_ff  [NUM_FRAMES];
   logic [IDX_W-1:0]  rank_in  [NUM_FRAMES];
   logic [PIN_W-1:0]  pin_ff   [NUM_FRAMES];
   logic [PIN_W-1:0]  pin_in   [NUM_FRAMES];
   logic [HIST_W-1:0] hist_ff  [NUM_FRAMES];
   logic [HIST_W-1:0] hist_in  [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] used_ff, used_in, dirty_ff, dirty_in;

   logic [CNT_W-1:0] reads_ff, reads_in, writes_ff, writes_in;

   // latched request and scan results
   req_payload_type   rq_ff;
   cand_type          hit_ff, hit_in, vic_ff, vic_in, ka_ff, ka_in, kb_ff, kb_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [UCNT_W-1:0] ucnt_ff, ucnt_in;

   // result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic     is_lru, is_lruk, out_free, cur_unp;
   cand_type cur;

   assign is_lru  = (mode_ff == POL_LRU) || (mode_ff == POL_LRUK);
   assign is_lruk = (mode_ff == POL_LRUK);
   assign out_free = !out_valid_ff || !rsp_stall;

   // current frame of the walk
   always_comb begin
      cur.found = 1'b1;
      cur.fidx  = idx;
      cur.rank  = rank_ff[idx];
      cur.hist  = hist_ff[idx];
      cur.pin   = pin_ff[idx];
      cur.dirty = dirty_ff[idx];
      cur_unp   = used_ff[idx] && (pin_ff[idx] == '0);
   end

   // status toward the sequencer
   always_comb begin
      stat.out_free   = out_free;
      stat.is_flush   = (rq_ff.req_type == REQ_FLUSH);
      stat.any_dirty  = |(used_ff & dirty_ff);
      stat.flush_hit  = used_ff[idx] && dirty_ff[idx];
      stat.flush_more = 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (IDX_W'(i) > idx && used_ff[i] && dirty_ff[i]) begin
            stat.flush_more = 1'b1;
         end
      end
   end

   // accumulate hit, free frame and victim candidates over the walk
   always_comb begin
      hit_in      = hit_ff;
      vic_in      = vic_ff;
      ka_in       = ka_ff;
      kb_in       = kb_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      ucnt_in     = ucnt_ff;
      if (cmd.load_req) begin
         hit_in  = '0;
         vic_in  = '0;
         ka_in   = '0;
         kb_in   = '0;
         free_in = 1'b0;
         ucnt_in = '0;
      end else if (cmd.scan_en) begin
         ucnt_in = ucnt_ff + UCNT_W'(used_ff[idx]);
         if (!hit_ff.found && used_ff[idx] && page_ff[idx] == rq_ff.page_number) begin
            hit_in = cur;
         end
         if (!free_ff && !used_ff[idx]) begin
            free_in     = 1'b1;
            free_idx_in = idx;
         end
         if (cur_unp && (!vic_ff.found ||
                         (is_lru ? cur.rank > vic_ff.rank : cur.rank < vic_ff.rank))) begin
            vic_in = cur;
         end
         if (cur_unp && cur.hist < hist_k_ff && (!ka_ff.found || cur.rank > ka_ff.rank)) begin
            ka_in = cur;
         end
         if (cur_unp && (!kb_ff.found || cur.hist < kb_ff.hist ||
                         (cur.hist == kb_ff.hist && cur.rank > kb_ff.rank))) begin
            kb_in = cur;
         end
      end
   end

   // apply the request to the frame table and build the result
   always_comb begin
      cand_type          vict;
      logic [IDX_W-1:0]  f;
      logic              evict, move;
      logic [HIST_W-1:0] hnew;

      page_in   = page_ff;
      rank_in   = rank_ff;
      pin_in    = pin_ff;
      hist_in   = hist_ff;
      used_in   = used_ff;
      dirty_in  = dirty_ff;
      reads_in  = reads_ff;
      writes_in = writes_ff;
      out_in    = out_ff;
      vict      = is_lruk ? (ka_ff.found ? ka_ff : kb_ff) : vic_ff;
      evict     = !free_ff;
      f         = free_ff ? free_idx_ff : vict.fidx;
      hnew      = (hit_ff.hist == HIST_MAX) ? HIST_MAX : hit_ff.hist + 1'b1;
      move      = (mode_ff == POL_LRU) || (is_lruk && hnew >= hist_k_ff);

      if (cmd.apply) begin
         out_in        = '0;
         out_in.status = ST_OK;
         out_in.last   = 1'b1;
         case (rq_ff.req_type)
            REQ_PIN: begin
               if (hit_ff.found) begin
                  if (hit_ff.pin == PIN_MAX) begin
                     out_in.status = ST_PIN_FULL;
                  end else begin
                     // count the pin, refresh recency
                     if (move) begin
                        for (int i = 0; i < NUM_FRAMES; i++) begin
                           if (IDX_W'(i) != hit_ff.fidx && used_ff[i] &&
                               rank_ff[i] < hit_ff.rank) begin
                              rank_in[i] = rank_ff[i] + 1'b1;
                           end
                        end
                        rank_in[hit_ff.fidx] = '0;
                     end
                     if (is_lruk) begin
                        hist_in[hit_ff.fidx] = move ? '0 : hnew;
                     end
                     pin_in[hit_ff.fidx] = hit_ff.pin + 1'b1;
                     out_in.frame_index  = FRAME_W'(hit_ff.fidx);
                  end
               end else if (free_ff || vict.found) begin
                  // drop the victim, if any, from the order, then insert the new page
                  for (int i = 0; i < NUM_FRAMES; i++) begin
                     if (IDX_W'(i) != f && used_ff[i]) begin
                        rank_in[i] = rank_ff[i] - IDX_W'(evict && rank_ff[i] > vict.rank)
                                     + IDX_W'(is_lru);
                     end
                  end
                  rank_in[f]  = is_lru ? '0 : IDX_W'(ucnt_ff - UCNT_W'(evict));
                  page_in[f]  = rq_ff.page_number;
                  hist_in[f]  = '0;
                  dirty_in[f] = 1'b0;
                  pin_in[f]   = PIN_W'(1);
                  used_in[f]  = 1'b1;
                  reads_in    = reads_ff + 1'b1;
                  if (evict && vict.dirty) begin
                     writes_in              = writes_ff + 1'b1;
                     out_in.write_back      = 1'b1;
                     out_in.write_back_page = page_ff[f];
                  end
                  out_in.frame_index    = FRAME_W'(f);
                  out_in.load_from_disk = 1'b1;
               end else begin
                  out_in.status = ST_ALL_PIN;
               end
            end
            REQ_UNPIN: begin
               if (!hit_ff.found) begin
                  out_in.status = ST_NOT_FOUND;
               end else if (hit_ff.pin == '0) begin
                  out_in.status = ST_NOT_PIN;
               end else begin
                  pin_in[hit_ff.fidx] = hit_ff.pin - 1'b1;
                  out_in.frame_index  = FRAME_W'(hit_ff.fidx);
               end
            end
            REQ_DIRTY: begin
               if (!hit_ff.found) begin
                  out_in.status = ST_NOT_FOUND;
               end else begin
                  dirty_in[hit_ff.fidx] = 1'b1;
                  out_in.frame_index    = FRAME_W'(hit_ff.fidx);
               end
            end
            REQ_FORCE: begin
               if (!hit_ff.found) begin
                  out_in.status = ST_NOT_FOUND;
               end else begin
                  out_in.frame_index = FRAME_W'(hit_ff.fidx);
                  if (hit_ff.dirty) begin
                     dirty_in[hit_ff.fidx]  = 1'b0;
                     writes_in              = writes_ff + 1'b1;
                     out_in.write_back      = 1'b1;
                     out_in.write_back_page = rq_ff.page_number;
                  end
               end
            end
            default: begin
               // empty flush and unknown requests answer plain ok
            end
         endcase
         out_in.read_count  = reads_in;
         out_in.write_count = writes_in;
      end else if (cmd.flush_emit) begin
         // write back one dirty frame of a flush
         dirty_in[idx]          = 1'b0;
         writes_in              = writes_ff + 1'b1;
         out_in                 = '0;
         out_in.status          = ST_OK;
         out_in.frame_index     = FRAME_W'(idx);
         out_in.write_back      = 1'b1;
         out_in.write_back_page = page_ff[idx];
         out_in.read_count      = reads_ff;
         out_in.write_count     = writes_in;
         out_in.last            = !stat.flush_more;
      end
   end

   // hold the result until taken
   always_comb begin
      if (cmd.apply || cmd.flush_emit) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= POL_FIFO;
         hist_k_ff    <= HIST_W'(1);
         used_ff      <= '0;
         dirty_ff     <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            pin_ff[i]  <= '0;
            hist_ff[i] <= '0;
         end
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_POLICY: mode_ff   <= csr_write_data[MODE_W-1:0];
               CSR_HIST_K: hist_k_ff <= csr_write_data[HIST_W-1:0];
               default:    mode_ff   <= mode_ff;
            endcase
         end
         used_ff      <= used_in;
         dirty_ff     <= dirty_in;
         reads_ff     <= reads_in;
         writes_ff    <= writes_in;
         out_valid_ff <= out_valid_in;
         pin_ff       <= pin_in;
         hist_ff      <= hist_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rq_ff <= req_data;
      end
      page_ff     <= page_in;
      rank_ff     <= rank_in;
      hit_ff      <= hit_in;
      vic_ff      <= vic_in;
      ka_ff       <= ka_in;
      kb_ff       <= kb_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      ucnt_ff     <= ucnt_in;
      out_ff      <= out_in;
   end

endmodule
`default_nettype wire

>>> sv/page_buffer_pool_replacement_core.sv
// ---------------------------------------------------------------------------
// page_buffer_pool_replacement_core
// Frame table of a page buffer pool with FIFO, LRU and LRU-K replacement.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Handshake           | Payload
//  req_     | in        | req_valid/req_stall | req_payload_type
//  rsp_     | out       | rsp_valid/rsp_stall | rsp_payload_type
//  csr_     | in        | csr_write_en        | csr_index, csr_write_data
//
//  Steps: a request is accepted, decoded, walked through the table one frame
//  per cycle, then applied once the output register is free. Flush all walks
//  the frames up to the last dirty one, one result per dirty frame, and waits
//  while the output register stalls; with nothing dirty it answers plain ok.
//  Reset is synchronous and clears all control state; no clearing pass.
//  A result waits in the output register while the next request is accepted.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module page_buffer_pool_replacement_core
   import pbpr_pkg::*;
#(
   parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);
   dp_cmd_type                      cmd;
   dp_stat_type                     stat;
   logic [$clog2(NUM_FRAMES)-1:0]   idx;

   pbpr_ctrl #(.NUM_FRAMES(NUM_FRAMES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .idx       (idx)
   );

   pbpr_dpath #(.NUM_FRAMES(NUM_FRAMES)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .idx            (idx),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire

>>> sv/pbpr_checker.sv
// ---------------------------------------------------------------------------
// pbpr_checker
// Port-level checks of the page buffer pool replacement core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "page_buffer_pool_replacement_core_assert.svh"
module pbpr_checker
   import pbpr_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_data
);
   // stalled result holds
   `PBPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // an error ends the request and orders no IO
   `PBPR_ASSERT_NOW(a_err_plain, clock, reset, rsp_valid && rsp_data.status != ST_OK, rsp_data.last && !rsp_data.write_back && !rsp_data.load_from_disk)

   // a load ends its request
   `PBPR_ASSERT_NOW(a_load_last, clock, reset, rsp_valid && rsp_data.load_from_disk, rsp_data.last)

   // a result without write-back names no page
   `PBPR_ASSERT_NOW(a_wb_page, clock, reset, rsp_valid && !rsp_data.write_back, rsp_data.write_back_page == '0)

endmodule

bind page_buffer_pool_replacement_core pbpr_checker u_pbpr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
